>>> rtl/core/binary_erosion_centroid_defines.svh
// Assertion macros for the checker file of the erosion centroid block.
`ifndef BINARY_EROSION_CENTROID_DEFINES_SVH
`define BINARY_EROSION_CENTROID_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define BEC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define BEC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/bec_pkg.sv
// Shared constants and types of the binary erosion centroid block.
package bec_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int SUM_W     = 40;
    localparam int CNT_W     = 21;
    localparam int COORD_W   = 10;
    localparam int WIN_W     = 9;
    localparam int LINE_BITS = 2;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd160;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd120;
    localparam logic [CNT_W-1:0] CNT_MAX          = {CNT_W{1'b1}};
    localparam logic [WIN_W-1:0] WIN_FULL         = {WIN_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 'd0,
        REG_FRAME_HEIGHT = 'd1
    } cfg_reg_t;

    // Sums of one finished frame, valid for the cycle of its last pixel.
    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] sum_x;
        logic [SUM_W-1:0] sum_y;
        logic [CNT_W-1:0] count;
    } frame_totals_t;

    // Request to the shared divider.
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

endpackage

>>> rtl/core/bec_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module bec_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/bec_div.sv
// Restoring divider, one quotient bit per cycle, keeping the low quotient bits.
module bec_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bec_pkg::div_req_t            req,
    output logic                         done,
    output logic [bec_pkg::COORD_W-1:0]  quotient
);

    localparam int SUM_W   = bec_pkg::SUM_W;
    localparam int CNT_W   = bec_pkg::CNT_W;
    localparam int COORD_W = bec_pkg::COORD_W;
    localparam int STEP_W  = $clog2(SUM_W);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t             state_reg;
    logic               done_reg;
    logic [SUM_W-1:0]   dvd_reg;
    logic [CNT_W-1:0]   dsr_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [COORD_W-1:0] quot_reg;
    logic [STEP_W-1:0]  step_reg;

    logic [CNT_W:0]     trial;
    logic [CNT_W:0]     diff;
    logic               fits;
    logic [CNT_W-1:0]   rem_next;

    // The partial remainder stays below the divisor, so the trial value fits
    // one bit wider than the divisor.
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[SUM_W-1]};
        fits     = (trial >= {1'b0, dsr_reg});
        diff     = trial - {1'b0, dsr_reg};
        rem_next = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            dvd_reg   <= '0;
            dsr_reg   <= '0;
            rem_reg   <= '0;
            quot_reg  <= '0;
            step_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req.start)
                    begin
                        dvd_reg   <= req.dividend;
                        dsr_reg   <= req.divisor;
                        rem_reg   <= '0;
                        quot_reg  <= '0;
                        step_reg  <= '0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    dvd_reg  <= {dvd_reg[SUM_W-2:0], 1'b0};
                    rem_reg  <= rem_next;
                    quot_reg <= {quot_reg[COORD_W-2:0], fits};
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(SUM_W - 1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

>>> rtl/core/bec_accum.sv
// Erosion window, survivor test and per-frame coordinate sums.
module bec_accum #(
    parameter int MAX_WIDTH  = bec_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bec_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pix_valid,
    input  logic [$clog2(MAX_WIDTH)-1:0]      pix_col,
    input  logic [$clog2(MAX_HEIGHT)-1:0]     pix_row,
    input  logic                              pix_bit,
    input  logic                              pix_last,
    input  logic [bec_pkg::LINE_BITS-1:0]     line_data,
    output logic [bec_pkg::LINE_BITS-1:0]     wb_data,
    output bec_pkg::frame_totals_t            totals
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int SUM_W = bec_pkg::SUM_W;
    localparam int CNT_W = bec_pkg::CNT_W;
    localparam int WIN_W = bec_pkg::WIN_W;

    logic [WIN_W-1:0] window_reg;
    logic [SUM_W-1:0] sum_x_reg;
    logic [SUM_W-1:0] sum_y_reg;
    logic [CNT_W-1:0] count_reg;

    logic [2:0]       triple;
    logic [WIN_W-1:0] window_next;
    logic             survive;
    logic [COL_W-1:0] col_m1;
    logic [ROW_W-1:0] row_m1;
    logic [SUM_W-1:0] sum_x_next;
    logic [SUM_W-1:0] sum_y_next;
    logic [CNT_W-1:0] count_next;

    // Line data holds the row two above in bit 1 and the row just above in bit 0.
    always_comb
    begin
        triple      = {line_data[1], line_data[0], pix_bit};
        window_next = {window_reg[WIN_W-4:0], triple};
        survive     = pix_valid && (pix_col >= COL_W'(2)) && (pix_row >= ROW_W'(2))
                      && (window_next == bec_pkg::WIN_FULL);
        col_m1      = pix_col - COL_W'(1);
        row_m1      = pix_row - ROW_W'(1);
        sum_x_next  = survive ? sum_x_reg + SUM_W'(col_m1) : sum_x_reg;
        sum_y_next  = survive ? sum_y_reg + SUM_W'(row_m1) : sum_y_reg;
        count_next  = (survive && (count_reg != bec_pkg::CNT_MAX))
                      ? count_reg + CNT_W'(1) : count_reg;
        wb_data     = {line_data[0], pix_bit};

        totals.valid = pix_valid && pix_last;
        totals.sum_x = sum_x_next;
        totals.sum_y = sum_y_next;
        totals.count = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            count_reg  <= '0;
        end
        else if (pix_valid)
        begin
            window_reg <= window_next;
            if (pix_last)
            begin
                sum_x_reg <= '0;
                sum_y_reg <= '0;
                count_reg <= '0;
            end
            else
            begin
                sum_x_reg <= sum_x_next;
                sum_y_reg <= sum_y_next;
                count_reg <= count_next;
            end
        end
    end

endmodule

>>> rtl/core/binary_erosion_centroid.sv
// Top level of the 3x3 binary erosion block with survivor centroid output.
//
// Pixels enter in raster order on pixel_valid/pixel_stall/pixel_bit, one per
// transaction. Within a frame the block takes one pixel per clock. The two
// line buffers live in one 2-bit wide RAM indexed by column: a pixel reads its
// column when it is taken and writes the shifted pair back in the next cycle.
// The configuration channel (cfg_valid/cfg_ready, always ready) sets the frame
// width and height; writes belong in idle time between frames.
// After the last pixel of a frame the sums go to a shared bit-serial divider,
// which computes the column quotient and then the row quotient at one bit per
// cycle. The result transaction follows the row quotient, or comes without any
// division when no pixel survived; pixel input is stalled over that time.
// The result sits in an output register: while the receiver asserts
// result_stall it holds, and the block already takes the next frame's pixels.
// After reset the line RAM is swept to zero, one entry per cycle, so pixel
// input stays stalled until the sweep ends; configuration writes are taken.
module binary_erosion_centroid #(
    parameter int MAX_WIDTH  = bec_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bec_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bec_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bec_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            pixel_valid,
    output logic                            pixel_stall,
    input  logic                            pixel_bit,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [bec_pkg::COORD_W-1:0]     center_x,
    output logic [bec_pkg::COORD_W-1:0]     center_y,
    output logic [bec_pkg::CNT_W-1:0]       survivor_count,
    output logic                            found
);

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int CFG_W     = bec_pkg::CFG_W;
    localparam int SUM_W     = bec_pkg::SUM_W;
    localparam int CNT_W     = bec_pkg::CNT_W;
    localparam int COORD_W   = bec_pkg::COORD_W;
    localparam int LINE_BITS = bec_pkg::LINE_BITS;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_RUN,
        ST_DIV_X,
        ST_DIV_Y,
        ST_HOLD
    } state_t;

    // Configuration registers.
    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;

    // Raster position of the next pixel and the pixel in the read-back stage.
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic             s1_valid_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic             s1_bit_reg;
    logic             s1_last_reg;

    // Control and result registers.
    state_t             state_reg;
    logic [COL_W-1:0]   clr_addr_reg;
    logic [SUM_W-1:0]   sum_y_hold_reg;
    logic [CNT_W-1:0]   count_hold_reg;
    logic [COORD_W-1:0] qx_reg;
    logic [COORD_W-1:0] qy_reg;
    logic               result_valid_reg;
    logic [COORD_W-1:0] center_x_reg;
    logic [COORD_W-1:0] center_y_reg;
    logic [CNT_W-1:0]   survivor_count_reg;
    logic               found_reg;

    logic [COL_W-1:0]       last_col;
    logic [ROW_W-1:0]       last_row;
    logic                   col_end;
    logic                   row_end;
    logic                   pixel_accept;
    logic                   ram_wr_en;
    logic [COL_W-1:0]       ram_wr_addr;
    logic [LINE_BITS-1:0]   ram_wr_data;
    logic [LINE_BITS-1:0]   line_data;
    logic [LINE_BITS-1:0]   wb_data;
    bec_pkg::frame_totals_t totals;
    bec_pkg::div_req_t      div_req;
    logic                   div_done;
    logic [COORD_W-1:0]     div_quot;

    // Sizes outside 3..MAX are clamped; the last column and row are what the
    // raster counters compare against. A size lowered below the current
    // position ends the row or frame at the next pixel.
    always_comb
    begin
        if (frame_width_reg < CFG_W'(3))
        begin
            last_col = COL_W'(2);
        end
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
        begin
            last_col = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            last_col = COL_W'(frame_width_reg - CFG_W'(1));
        end

        if (frame_height_reg < CFG_W'(3))
        begin
            last_row = ROW_W'(2);
        end
        else if (32'(frame_height_reg) > 32'(MAX_HEIGHT))
        begin
            last_row = ROW_W'(MAX_HEIGHT - 1);
        end
        else
        begin
            last_row = ROW_W'(frame_height_reg - CFG_W'(1));
        end
    end

    assign col_end = (col_reg >= last_col);
    assign row_end = (row_reg >= last_row);

    // Input is held off during the RAM sweep, while a frame end moves through
    // the read-back stage, and until its result has reached the output register.
    assign pixel_stall  = (state_reg != ST_RUN) || (s1_valid_reg && s1_last_reg);
    assign pixel_accept = pixel_valid && !pixel_stall;
    assign cfg_ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= bec_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= bec_pkg::FRAME_HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bec_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                bec_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Raster counters and the register stage that waits for the RAM read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_col_reg   <= '0;
            s1_row_reg   <= '0;
            s1_bit_reg   <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= pixel_accept;
            if (pixel_accept)
            begin
                s1_col_reg  <= col_reg;
                s1_row_reg  <= row_reg;
                s1_bit_reg  <= pixel_bit;
                s1_last_reg <= col_end && row_end;
                if (col_end)
                begin
                    col_reg <= '0;
                    row_reg <= row_end ? '0 : row_reg + ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
        end
    end

    // The sweep owns the write port after reset; afterwards each pixel writes
    // its column back in the cycle after reading it. Since the width is at least
    // three, two pixels in flight never share a column, so no forwarding is
    // needed around the RAM.
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_reg;
            ram_wr_data = '0;
        end
        else
        begin
            ram_wr_en   = s1_valid_reg;
            ram_wr_addr = s1_col_reg;
            ram_wr_data = wb_data;
        end
    end

    bec_ram #(
        .WIDTH (LINE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (pixel_accept),
        .rd_addr (col_reg),
        .rd_data (line_data)
    );

    bec_accum #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (s1_valid_reg),
        .pix_col   (s1_col_reg),
        .pix_row   (s1_row_reg),
        .pix_bit   (s1_bit_reg),
        .pix_last  (s1_last_reg),
        .line_data (line_data),
        .wb_data   (wb_data),
        .totals    (totals)
    );

    // The column sum is divided first, straight from the frame totals; the
    // row sum follows from the hold register once the first quotient is done.
    always_comb
    begin
        if (state_reg == ST_RUN)
        begin
            div_req.start    = totals.valid && (totals.count != '0);
            div_req.dividend = totals.sum_x;
            div_req.divisor  = totals.count;
        end
        else
        begin
            div_req.start    = (state_reg == ST_DIV_X) && div_done;
            div_req.dividend = sum_y_hold_reg;
            div_req.divisor  = count_hold_reg;
        end
    end

    bec_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Frame-end sequencing and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_CLEAR;
            clr_addr_reg       <= '0;
            sum_y_hold_reg     <= '0;
            count_hold_reg     <= '0;
            qx_reg             <= '0;
            qy_reg             <= '0;
            result_valid_reg   <= 1'b0;
            center_x_reg       <= '0;
            center_y_reg       <= '0;
            survivor_count_reg <= '0;
            found_reg          <= 1'b0;
        end
        else
        begin
            if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + COL_W'(1);
                    if (clr_addr_reg == COL_W'(MAX_WIDTH - 1))
                    begin
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (totals.valid)
                    begin
                        sum_y_hold_reg <= totals.sum_y;
                        count_hold_reg <= totals.count;
                        if (totals.count == '0)
                        begin
                            // Nothing survived: report zero centers, no division.
                            qx_reg    <= '0;
                            qy_reg    <= '0;
                            state_reg <= ST_HOLD;
                        end
                        else
                        begin
                            state_reg <= ST_DIV_X;
                        end
                    end
                end
                ST_DIV_X:
                begin
                    if (div_done)
                    begin
                        qx_reg    <= div_quot;
                        state_reg <= ST_DIV_Y;
                    end
                end
                ST_DIV_Y:
                begin
                    if (div_done)
                    begin
                        qy_reg    <= div_quot;
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD:
                begin
                    if (!result_valid_reg || !result_stall)
                    begin
                        result_valid_reg   <= 1'b1;
                        center_x_reg       <= qx_reg;
                        center_y_reg       <= qy_reg;
                        survivor_count_reg <= count_hold_reg;
                        found_reg          <= (count_hold_reg != '0);
                        state_reg          <= ST_RUN;
                    end
                end
                default:
                begin
                    state_reg <= ST_CLEAR;
                end
            endcase
        end
    end

    assign result_valid   = result_valid_reg;
    assign center_x       = center_x_reg;
    assign center_y       = center_y_reg;
    assign survivor_count = survivor_count_reg;
    assign found          = found_reg;

endmodule

>>> rtl/core/bec_checker.sv
// Port-level checker for the erosion centroid block and its bind statement.
`include "binary_erosion_centroid_defines.svh"

module bec_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         pixel_stall,
    input logic                         result_valid,
    input logic                         result_stall,
    input logic [bec_pkg::COORD_W-1:0]  center_x,
    input logic [bec_pkg::COORD_W-1:0]  center_y,
    input logic [bec_pkg::CNT_W-1:0]    survivor_count,
    input logic                         found
);

    // A stalled result transaction keeps its whole payload.
    `BEC_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(center_x) && $stable(center_y) && $stable(survivor_count) && $stable(found), "result payload changed while stalled")

    // The found flag tells exactly whether any pixel survived.
    `BEC_ASSERT_IMPL(a_found_count, result_valid, found == (survivor_count != '0), "found disagrees with survivor count")

    // An empty frame reports both centers as zero.
    `BEC_ASSERT_IMPL(a_empty_center, result_valid && !found, (center_x == '0) && (center_y == '0), "nonzero center without survivors")

    // A new result is only loaded while pixel input is held off for the frame end.
    `BEC_ASSERT_IMPL(a_result_busy, $rose(result_valid), $past(pixel_stall), "result appeared while pixel input was open")

endmodule

bind binary_erosion_centroid bec_checker u_bec_checker (.*);

>>> sim/centroid_checker.sv
// Checker for the erosion centroid block: watches all channels, predicts each frame result.
module centroid_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [bec_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bec_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              pixel_valid,
    input  logic                              pixel_stall,
    input  logic                              pixel_bit,
    input  logic                              result_valid,
    input  logic                              result_stall,
    input  logic [bec_pkg::COORD_W-1:0]       center_x,
    input  logic [bec_pkg::COORD_W-1:0]       center_y,
    input  logic [bec_pkg::CNT_W-1:0]         survivor_count,
    input  logic                              found,
    output int                                error_count,
    output int                                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WIDTH_DEF  = bec_pkg::MAX_WIDTH_DEF;
    localparam int MAX_HEIGHT_DEF = bec_pkg::MAX_HEIGHT_DEF;
    localparam int CFG_W          = bec_pkg::CFG_W;
    localparam int SUM_W          = bec_pkg::SUM_W;
    localparam int CNT_W          = bec_pkg::CNT_W;
    localparam int COORD_W        = bec_pkg::COORD_W;
    localparam int WIN_W          = bec_pkg::WIN_W;

    typedef struct packed {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [CNT_W-1:0]   cnt;
        logic               fnd;
    } centroid_t;

    centroid_t expected_centroids[$];

    logic               upper_row [MAX_WIDTH_DEF];
    logic               middle_row [MAX_WIDTH_DEF];
    logic [WIN_W-1:0]   window;
    int unsigned        col;
    int unsigned        row;
    logic [SUM_W-1:0]   col_sum;
    logic [SUM_W-1:0]   row_sum;
    logic [CNT_W-1:0]   hits;
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
        if (v < 3)
            return 3;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Shifts one pixel into the window and accumulates the survivor of the centre.
    task automatic erode_pixel(input logic px);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        logic [2:0]  column_bits;
        centroid_t   res;
        w = clamp_dim(width_reg, MAX_WIDTH_DEF);
        h = clamp_dim(height_reg, MAX_HEIGHT_DEF);
        c = col;
        column_bits   = {upper_row[c], middle_row[c], px};
        window        = {window[5:0], column_bits};
        upper_row[c]  = middle_row[c];
        middle_row[c] = px;
        if (c >= 2 && row >= 2 && window == bec_pkg::WIN_FULL)
        begin
            col_sum = col_sum + SUM_W'(c - 1);
            row_sum = row_sum + SUM_W'(row - 1);
            if (hits != bec_pkg::CNT_MAX)
                hits = hits + 1'b1;
        end
        if (c + 1 < w)
            col = c + 1;
        else
        begin
            col = 0;
            if (row + 1 < h)
                row = row + 1;
            else
            begin
                row = 0;
                if (hits != 0)
                begin
                    res.cx  = COORD_W'(col_sum / hits);
                    res.cy  = COORD_W'(row_sum / hits);
                    res.cnt = hits;
                    res.fnd = 1'b1;
                end
                else
                    res = '0;
                expected_centroids.push_back(res);
                col_sum = '0;
                row_sum = '0;
                hits    = '0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        centroid_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WIDTH_DEF; i++)
            begin
                upper_row[i]  = 1'b0;
                middle_row[i] = 1'b0;
            end
            window      = '0;
            col         = 0;
            row         = 0;
            col_sum     = '0;
            row_sum     = '0;
            hits        = '0;
            width_reg   = bec_pkg::FRAME_WIDTH_RST;
            height_reg  = bec_pkg::FRAME_HEIGHT_RST;
            expected_centroids.delete();
            error_count = 0;
            pending     = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_centroids.size() == 0)
                begin
                    $error("result transaction with no frame pending");
                    error_count++;
                end
                else
                begin
                    want = expected_centroids.pop_front();
                    if (center_x !== want.cx)
                    begin
                        $error("center_x: expected %0d, actual %0d", want.cx, center_x);
                        error_count++;
                    end
                    if (center_y !== want.cy)
                    begin
                        $error("center_y: expected %0d, actual %0d", want.cy, center_y);
                        error_count++;
                    end
                    if (survivor_count !== want.cnt)
                    begin
                        $error("survivor_count: expected %0d, actual %0d",
                               want.cnt, survivor_count);
                        error_count++;
                    end
                    if (found !== want.fnd)
                    begin
                        $error("found: expected %0d, actual %0d", want.fnd, found);
                        error_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == bec_pkg::REG_FRAME_WIDTH)
                    width_reg = cfg_data;
                else if (cfg_index == bec_pkg::REG_FRAME_HEIGHT)
                    height_reg = cfg_data;
            end
            if (pixel_valid && !pixel_stall)
                erode_pixel(pixel_bit);
            pending = expected_centroids.size();
        end
    end

endmodule

>>> sim/tb_top.sv
// Top of the erosion centroid testbench: clock, reset, frame stimulus and the verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CFG_IDX_W      = bec_pkg::CFG_IDX_W;
    localparam int CFG_W          = bec_pkg::CFG_W;
    localparam int COORD_W        = bec_pkg::COORD_W;
    localparam int CNT_W          = bec_pkg::CNT_W;
    localparam int MAX_WIDTH_DEF  = bec_pkg::MAX_WIDTH_DEF;
    localparam int MAX_HEIGHT_DEF = bec_pkg::MAX_HEIGHT_DEF;

    // Indexes past the register list; the block must ignore writes to them.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

    // Idle pause that follows once every pending frame result has been taken.
    localparam int SETTLE_CYCLES = 120;

    // Content of one frame.
    typedef enum logic [2:0] {
        FILL_ZERO,
        FILL_ONE,
        FILL_NOISE,
        FILL_DENSE,
        FILL_BLOB
    } fill_t;

    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 cfg_valid      = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index      = '0;
    logic [CFG_W-1:0]     cfg_data       = '0;
    logic                 pixel_valid    = 1'b0;
    logic                 pixel_stall;
    logic                 pixel_bit      = 1'b0;
    logic                 result_valid;
    logic                 result_stall   = 1'b0;
    logic [COORD_W-1:0]   center_x;
    logic [COORD_W-1:0]   center_y;
    logic [CNT_W-1:0]     survivor_count;
    logic                 found;

    int                   checker_errors;
    int                   checker_pending;

    // Raw register values as last written; the frame size seen by the block is
    // these values clamped to the legal range.
    logic [CFG_W-1:0]     cur_w          = bec_pkg::FRAME_WIDTH_RST;
    logic [CFG_W-1:0]     cur_h          = bec_pkg::FRAME_HEIGHT_RST;

    // When set, the matching side runs without any idle cycles for the frame.
    bit                   tx_burst       = 1'b0;
    bit                   rx_burst       = 1'b0;

    int                   pixels_sent    = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    binary_erosion_centroid DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pixel_valid    (pixel_valid),
        .pixel_stall    (pixel_stall),
        .pixel_bit      (pixel_bit),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .center_x       (center_x),
        .center_y       (center_y),
        .survivor_count (survivor_count),
        .found          (found)
    );

    centroid_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pixel_valid    (pixel_valid),
        .pixel_stall    (pixel_stall),
        .pixel_bit      (pixel_bit),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .center_x       (center_x),
        .center_y       (center_y),
        .survivor_count (survivor_count),
        .found          (found),
        .error_count    (checker_errors),
        .pending        (checker_pending)
    );

    // Legal frame dimension for a raw register value.
    function automatic int frame_dim(input logic [CFG_W-1:0] v, input int hi);
        if (v < 3)
            return 3;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Drives one pixel transaction. Called at a falling edge and returns at the
    // falling edge after the pixel was taken, with valid still high, so that a
    // back-to-back pixel never lowers and raises valid in the same step.
    task automatic send_pixel(input logic px);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_bit   <= px;
        do @(posedge clk); while (pixel_stall);
        @(negedge clk);
    endtask

    // One configuration transaction. Valid is left high; the caller lowers it
    // once its sequence of writes is done.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // Stops the pixel stream and waits until every frame result has been taken,
    // then lets the divider and the line RAM write-back run out.
    task automatic wait_idle();
        pixel_valid <= 1'b0;
        while (checker_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Reprograms the frame size between frames. Now and then a write to an index
    // past the register list is mixed in; it must leave the size alone.
    task automatic set_frame_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        wait_idle();
        if ($urandom_range(0, 1) == 1)
            write_reg($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3,
                      CFG_W'($urandom));
        write_reg(bec_pkg::REG_FRAME_WIDTH, w);
        write_reg(bec_pkg::REG_FRAME_HEIGHT, h);
        cfg_valid <= 1'b0;
        cur_w = w;
        cur_h = h;
    endtask

    // Streams one whole frame in raster order. A blob frame holds a random
    // rectangle of mostly set pixels on a sparse background, which is what lets
    // pixels survive the erosion in clusters of varied shape and position.
    task automatic send_frame(input fill_t mode);
        int  w;
        int  h;
        int  x0;
        int  x1;
        int  y0;
        int  y1;
        logic px;
        w  = frame_dim(cur_w, MAX_WIDTH_DEF);
        h  = frame_dim(cur_h, MAX_HEIGHT_DEF);
        x0 = $urandom_range(0, w - 1);
        x1 = $urandom_range(x0, w - 1);
        y0 = $urandom_range(0, h - 1);
        y1 = $urandom_range(y0, h - 1);
        for (int y = 0; y < h; y++)
        begin
            for (int x = 0; x < w; x++)
            begin
                unique case (mode)
                    FILL_ZERO:  px = 1'b0;
                    FILL_ONE:   px = 1'b1;
                    FILL_NOISE: px = 1'($urandom_range(0, 1));
                    FILL_DENSE: px = ($urandom_range(0, 7) != 0);
                    default:
                    begin
                        if (x >= x0 && x <= x1 && y >= y0 && y <= y1)
                            px = ($urandom_range(0, 15) != 0);
                        else
                            px = ($urandom_range(0, 15) == 0);
                    end
                endcase
                send_pixel(px);
            end
        end
        pixels_sent += w * h;
    endtask

    // Receiving side: once a result shows up it is held off for a random number
    // of cycles, unless the current frame runs without idling.
    initial
    begin
        int unsigned hold;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            while (!result_valid)
                @(negedge clk);
            hold = rx_burst ? 0 : $urandom_range(0, 15);
            if (hold != 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
        end
    end

    // Hard limit on the run, several times the slowest legal run.
    initial
    begin
        #1_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int    wide_frames;
        int    pick;
        fill_t mode;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;

        // Reset is applied once. The block then sweeps its line RAM, during
        // which pixel input is stalled; the handshake takes care of that.
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed frames. The smallest frame that is all ones leaves exactly
        // its centre pixel standing.
        set_frame_size(11'd3, 11'd3);
        send_frame(FILL_ONE);
        // Writes past the register list must not touch the 3x3 size; an empty
        // frame gives no survivors and zero centre fields.
        wait_idle();
        write_reg(REG_UNUSED_2, 11'h7FF);
        write_reg(REG_UNUSED_3, 11'h004);
        cfg_valid <= 1'b0;
        send_frame(FILL_ZERO);
        // A solid 5x5 frame erodes to its 3x3 core around (2, 2).
        set_frame_size(11'd5, 11'd5);
        send_frame(FILL_ONE);
        // Sizes below the minimum behave as 3.
        set_frame_size(11'd0, 11'd1);
        send_frame(FILL_ONE);
        set_frame_size(11'd2, 11'd2);
        send_frame(FILL_NOISE);

        // Random frames, mostly small so that results come often. A few wider
        // frames and out-of-range sizes are mixed in.
        wide_frames = 0;
        while (pixels_sent < 850)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                pick = $urandom_range(0, 15);
                if (pick == 0 && wide_frames < 4)
                begin
                    w = CFG_W'($urandom_range(9, 48));
                    h = CFG_W'($urandom_range(0, 3));
                    wide_frames++;
                end
                else if (pick == 1)
                begin
                    w = CFG_W'($urandom_range(0, 2));
                    h = CFG_W'($urandom_range(3, 6));
                end
                else if (pick == 2)
                begin
                    w = CFG_W'($urandom_range(3, 6));
                    h = CFG_W'($urandom_range(0, 2));
                end
                else
                begin
                    w = CFG_W'($urandom_range(3, 8));
                    h = CFG_W'($urandom_range(3, 8));
                end
                set_frame_size(w, h);
            end
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 19);
            if (pick < 2)
                mode = FILL_ZERO;
            else if (pick < 3)
                mode = FILL_ONE;
            else if (pick < 7)
                mode = FILL_NOISE;
            else if (pick < 12)
                mode = FILL_DENSE;
            else
                mode = FILL_BLOB;
            send_frame(mode);
        end

        // Drain: every frame result must arrive, and nothing may follow it.
        pixel_valid <= 1'b0;
        while (checker_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (checker_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
